// File: rtl/peu_pkg.sv
`timescale 1ns / 1ps
package peu_pkg;

    // Fixed-point format and divider depth
    localparam int Q_FRAC    = 24;
    localparam int DIV_STEPS = 25;
    localparam int CFG_W     = 25;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIME_STEP   = 2'd0;
    localparam logic [1:0] CFG_ACCEL_LIMIT = 2'd1;
    localparam logic [1:0] CFG_BORDER      = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] TIME_STEP_RST   = 25'd5033165;
    localparam logic [CFG_W-1:0] ACCEL_LIMIT_RST = 25'd671089;
    localparam logic [CFG_W-1:0] BORDER_RST      = 25'd16609444;

    localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
    localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic        [30:0] mass;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
    } t_out_item;

    // One axis after the input stage: force magnitude and sign split apart
    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic               neg;
        logic        [31:0] mag;
    } t_mag_lane;

    typedef struct packed {
        t_mag_lane [1:0] lane;
        logic     [30:0] mass;
    } t_mag_stage;

    // One axis inside the divider
    typedef struct packed {
        logic signed [31:0]          pos;
        logic signed [31:0]          vel;
        logic                        neg;
        logic                        zero;
        logic                        sat;
        logic                        nb;
        logic        [30:0]          rem;
        logic        [DIV_STEPS-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [1:0] lane;
        logic     [30:0] mass;
    } t_div_stage;

    // Clamp a widened sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Halve arithmetically, then negate
    function automatic logic signed [31:0] half_neg(input logic signed [31:0] v);
        logic signed [31:0] h;
        h = v >>> 1;
        return -h;
    endfunction

endpackage

// File: rtl/peu_div.sv
`timescale 1ns / 1ps
module peu_div import peu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic       i_valid,
    input  t_mag_stage i_item,
    output logic       o_valid,
    output t_div_stage o_item
);

    logic       [DIV_STEPS:0] r_vld;
    t_div_stage               r_st [DIV_STEPS+1];
    t_div_stage               n_st [DIV_STEPS+1];

    // Set up the quotient: detect overflow of 25 quotient bits and a zero force
    always_comb begin
        n_st[0].mass = i_item.mass;
        for (int l = 0; l < 2; l++) begin
            n_st[0].lane[l].pos  = i_item.lane[l].pos;
            n_st[0].lane[l].vel  = i_item.lane[l].vel;
            n_st[0].lane[l].neg  = i_item.lane[l].neg;
            n_st[0].lane[l].zero = (i_item.lane[l].mag == 32'd0);
            n_st[0].lane[l].sat  = (i_item.lane[l].mag >= {i_item.mass, 1'b0});
            n_st[0].lane[l].nb   = i_item.lane[l].mag[0];
            n_st[0].lane[l].rem  = i_item.lane[l].mag[31:1];
            n_st[0].lane[l].quo  = '0;
        end
    end

    // One restoring step per stage, one quotient bit each
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        always_comb begin
            logic [31:0] t;
            logic        ge;
            n_st[k] = r_st[k-1];
            for (int l = 0; l < 2; l++) begin
                t  = {r_st[k-1].lane[l].rem, r_st[k-1].lane[l].nb};
                ge = (t >= {1'b0, r_st[k-1].mass});
                n_st[k].lane[l].rem = ge ? 31'(t - {1'b0, r_st[k-1].mass}) : t[30:0];
                n_st[k].lane[l].quo = {r_st[k-1].lane[l].quo[DIV_STEPS-2:0], ge};
                n_st[k].lane[l].nb  = 1'b0;
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[DIV_STEPS-1:0], i_valid};
        end
    end

    for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_valid = r_vld[DIV_STEPS];
    assign o_item  = r_st[DIV_STEPS];

endmodule

// File: rtl/peu_kin.sv
`timescale 1ns / 1ps
module peu_kin import peu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [CFG_W-1:0] i_time_step,
    input  logic [CFG_W-1:0] i_accel_limit,
    input  logic [CFG_W-1:0] i_border,
    input  logic             i_valid,
    input  t_div_stage       i_item,
    output logic             o_valid,
    output t_out_item        o_item
);

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic               neg;
        logic [CFG_W-1:0]   amag;
    } t_acc_lane;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic               neg;
        logic [2*CFG_W-1:0] prod;
    } t_prod_lane;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
    } t_pv_lane;

    logic [3:0] r_vld;

    t_acc_lane  [1:0] r_acc,  n_acc;
    t_prod_lane [1:0] r_prod, n_prod;
    t_pv_lane   [1:0] r_vel,  n_vel;
    t_pv_lane   [1:0] r_pos,  n_pos;
    t_out_item        r_out,  n_out;

    // Clamp acceleration magnitude
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_acc[l].pos = i_item.lane[l].pos;
            n_acc[l].vel = i_item.lane[l].vel;
            n_acc[l].neg = i_item.lane[l].neg;
            if (i_item.lane[l].zero) begin
                n_acc[l].amag = '0;
            end else if (i_item.lane[l].sat || (i_item.lane[l].quo > i_accel_limit)) begin
                n_acc[l].amag = i_accel_limit;
            end else begin
                n_acc[l].amag = i_item.lane[l].quo;
            end
        end
    end

    // Scale by the timestep
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_prod[l].pos  = r_acc[l].pos;
            n_prod[l].vel  = r_acc[l].vel;
            n_prod[l].neg  = r_acc[l].neg;
            n_prod[l].prod = {{CFG_W{1'b0}}, r_acc[l].amag} * {{CFG_W{1'b0}}, i_time_step};
        end
    end

    // Add the velocity change, saturating
    always_comb begin
        logic        [25:0] dv;
        logic signed [33:0] dvs;
        logic signed [33:0] sum;
        for (int l = 0; l < 2; l++) begin
            dv  = r_prod[l].prod[2*CFG_W-1:Q_FRAC];
            dvs = $signed({8'd0, dv});
            if (r_prod[l].neg) begin
                dvs = -dvs;
            end
            sum = 34'(r_prod[l].vel) + dvs;
            n_vel[l].pos = r_prod[l].pos;
            n_vel[l].vel = sat32(sum);
        end
    end

    // Move the position by the new velocity, saturating
    always_comb begin
        logic signed [33:0] sum;
        for (int l = 0; l < 2; l++) begin
            sum = 34'(r_vel[l].pos) + 34'(r_vel[l].vel);
            n_pos[l].pos = sat32(sum);
            n_pos[l].vel = r_vel[l].vel;
        end
    end

    // Bounce off the upper border, then the lower one
    always_comb begin
        logic signed [31:0] b;
        logic signed [31:0] p [2];
        logic signed [31:0] v [2];
        b = $signed({7'd0, i_border});
        for (int l = 0; l < 2; l++) begin
            p[l] = r_pos[l].pos;
            v[l] = r_pos[l].vel;
            if (p[l] >= b) begin
                p[l] = b;
                v[l] = half_neg(v[l]);
            end
            if (p[l] <= -b) begin
                p[l] = -b;
                v[l] = half_neg(v[l]);
            end
        end
        n_out.new_pos_x = p[0];
        n_out.new_pos_y = p[1];
        n_out.new_vel_x = v[0];
        n_out.new_vel_y = v[1];
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else if (i_adv) begin
            r_vld   <= {r_vld[2:0], i_valid};
            o_valid <= r_vld[3];
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_acc  <= n_acc;
            r_prod <= n_prod;
            r_vel  <= n_vel;
            r_pos  <= n_pos;
            r_out  <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

// File: rtl/particle_euler_update.sv
`timescale 1ns / 1ps
// Particle update, one semi-implicit Euler step per item.
// Input channel: i_valid / o_stall with i_data (position, velocity, force,
// mass of one particle). Output channel: o_valid / i_stall with o_data (new
// position and velocity). An item moves when valid is high and stall is low.
// Configuration: write i_cfg_data to the register named by i_cfg_addr when
// i_cfg_we is high (0 time step, 1 acceleration limit, 2 border); other
// indexes are ignored. Write only while the pipeline is empty.
// Throughput: one item per cycle unless the receiver stalls. The input register
// loads at the accepting edge; after it come a quotient setup stage, the
// 25-stage quotient pipeline (one bit per stage) and five arithmetic stages
// (clamp, multiply, velocity sum, position sum, border bounce).
// When the receiver stalls while a result is shown, the whole pipeline
// freezes and o_stall rises; nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads the default registers
// (time step 0.3, acceleration limit 0.04, border 0.99).
module particle_euler_update import peu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_item         i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_item        o_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_time_step;
    logic [CFG_W-1:0] r_accel_limit;
    logic [CFG_W-1:0] r_border;

    logic       w_adv;
    logic       r_in_vld;
    t_mag_stage r_in, n_in;
    logic       w_div_vld;
    t_div_stage w_div;
    logic       w_out_vld;

    // Freeze everything while a shown result is stalled
    assign w_adv   = !(w_out_vld && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = w_out_vld;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step   <= TIME_STEP_RST;
            r_accel_limit <= ACCEL_LIMIT_RST;
            r_border      <= BORDER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TIME_STEP:   r_time_step   <= i_cfg_data;
                CFG_ACCEL_LIMIT: r_accel_limit <= i_cfg_data;
                CFG_BORDER:      r_border      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Split forces into magnitude and sign
    always_comb begin
        n_in.mass         = i_data.mass;
        n_in.lane[0].pos  = i_data.pos_x;
        n_in.lane[0].vel  = i_data.vel_x;
        n_in.lane[0].neg  = i_data.force_x[31];
        n_in.lane[0].mag  = i_data.force_x[31] ? 32'(-i_data.force_x) : i_data.force_x;
        n_in.lane[1].pos  = i_data.pos_y;
        n_in.lane[1].vel  = i_data.vel_y;
        n_in.lane[1].neg  = i_data.force_y[31];
        n_in.lane[1].mag  = i_data.force_y[31] ? 32'(-i_data.force_y) : i_data.force_y;
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_adv) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in <= n_in;
        end
    end

    peu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_in_vld),
        .i_item  (r_in),
        .o_valid (w_div_vld),
        .o_item  (w_div)
    );

    peu_kin u_kin (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_time_step   (r_time_step),
        .i_accel_limit (r_accel_limit),
        .i_border      (r_border),
        .i_valid       (w_div_vld),
        .i_item        (w_div),
        .o_valid       (w_out_vld),
        .o_item        (o_data)
    );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
    import peu_pkg::*;

    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int         WATCH_LIMIT = 4000;
    localparam int         HOLD_CYCLES = 150;
    localparam int         PIPE_DEPTH  = 40;
    localparam int         IDLE_PCT    = 13;
    localparam logic [CFG_W-1:0] REG_MAX = '1;
    localparam logic [CFG_W-1:0] REG_ONE = 25'd16777216;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    t_in_item         i_data;
    logic             o_valid;
    logic             i_stall;
    t_out_item        o_data;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_addr;
    logic [CFG_W-1:0] i_cfg_data;

    // Shadow copy of the configuration registers
    logic [CFG_W-1:0] step_reg;
    logic [CFG_W-1:0] limit_reg;
    logic [CFG_W-1:0] border_reg;

    t_out_item pending_updates[$];
    int        fail_count;
    int        quiet_cycles;
    int        src_idle_pct;
    int        sink_idle_pct;
    bit        hold_req;

    particle_euler_update u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Clamp to the signed 32-bit range
    function automatic longint clamp_word(input longint x);
        if (x > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // One axis: clamped acceleration, velocity and position sums, border bounce
    function automatic void advance_axis(input logic signed [31:0] pos,
                                         input logic signed [31:0] vel,
                                         input logic signed [31:0] frc,
                                         input logic [30:0] mass,
                                         output logic signed [31:0] npos,
                                         output logic signed [31:0] nvel);
        longint f, m, mag, q, d, v, p, b, lim;
        f   = frc;
        m   = mass;
        lim = limit_reg;
        mag = (f < 0) ? -f : f;
        if (mag == 0) begin
            q = 0;
        end else if (m == 0) begin
            q = lim;
        end else begin
            q = (mag << 24) / m;
            if (q > lim) begin
                q = lim;
            end
        end
        d = (q * longint'(step_reg)) >> 24;
        v = clamp_word(longint'(vel) + ((f < 0) ? -d : d));
        p = clamp_word(longint'(pos) + v);
        b = border_reg;
        // Upper wall first, then lower; a zero border hits both unless the position is negative
        if (p >= b) begin
            p = b;
            v = -(v >>> 1);
        end
        if (p <= -b) begin
            p = -b;
            v = -(v >>> 1);
        end
        npos = p[31:0];
        nvel = v[31:0];
    endfunction

    function automatic t_out_item euler_step(input t_in_item it);
        t_out_item r;
        logic signed [31:0] px, py, vx, vy;
        advance_axis(it.pos_x, it.vel_x, it.force_x, it.mass, px, vx);
        advance_axis(it.pos_y, it.vel_y, it.force_y, it.mass, py, vy);
        r.new_pos_x = px;
        r.new_pos_y = py;
        r.new_vel_x = vx;
        r.new_vel_y = vy;
        return r;
    endfunction

    function automatic t_in_item make_particle(input int px, input int py,
                                               input int vx, input int vy,
                                               input int fx, input int fy,
                                               input int unsigned m);
        t_in_item it;
        it.pos_x   = px;
        it.pos_y   = py;
        it.vel_x   = vx;
        it.vel_y   = vy;
        it.force_x = fx;
        it.force_y = fy;
        it.mass    = m[30:0];
        return it;
    endfunction

    function automatic int spread(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Mostly plausible particles near the box, some raw noise
    function automatic t_in_item rand_particle();
        t_in_item    it;
        int unsigned m;
        if ($urandom_range(9) < 2) begin
            it = make_particle($urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom);
        end else begin
            case ($urandom_range(4))
                0: m = 0;
                1: m = $urandom_range(255);
                2: m = $urandom;
                default: m = $urandom_range(32'h0400_0000);
            endcase
            it = make_particle(spread(20000000), spread(20000000),
                               spread(1 << 23), spread(1 << 23),
                               ($urandom_range(7) == 0) ? 0 : spread(1 << 26),
                               ($urandom_range(7) == 0) ? 0 : spread(1 << 26), m);
        end
        return it;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Predict on input acceptance, check on output acceptance, watch for hangs
    always @(posedge i_clk) begin
        t_out_item want;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            pending_updates = {pending_updates, euler_step(i_data)};
            moved = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            moved = 1'b1;
            if (pending_updates.size() == 0) begin
                $error("result with no item outstanding");
                fail_count++;
            end else begin
                want = pending_updates.pop_front();
                check_field("new_pos_x", want.new_pos_x, o_data.new_pos_x);
                check_field("new_pos_y", want.new_pos_y, o_data.new_pos_y);
                check_field("new_vel_x", want.new_vel_x, o_data.new_vel_x);
                check_field("new_vel_y", want.new_vel_y, o_data.new_vel_y);
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random stalls, or one long hold when asked
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_stall <= ($urandom_range(99) < sink_idle_pct);
        end
    end

    // Offer one item, with a random gap first; returns on a falling edge
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_updates.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TIME_STEP:   step_reg   = val;
            CFG_ACCEL_LIMIT: limit_reg  = val;
            CFG_BORDER:      border_reg = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] ts, input logic [CFG_W-1:0] lim,
                            input logic [CFG_W-1:0] bord);
        write_reg(CFG_TIME_STEP, ts);
        write_reg(CFG_ACCEL_LIMIT, lim);
        write_reg(CFG_BORDER, bord);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_item(rand_particle());
    endtask

    // Field extremes, zero mass, truncation and both walls at reset values
    task automatic test_directed();
        send_item(make_particle(0, 0, 0, 0, 0, 0, 32'h0100_0000));
        send_item(make_particle(0, 0, 0, 0, 1000, -1000, 0));
        send_item(make_particle(12345, -12345, 777, -777, 0, 0, 0));
        send_item(make_particle(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1));
        send_item(make_particle(16609444, -16609444, 0, 0, 0, 0, 32'h0100_0000));
        send_item(make_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        send_item(make_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 5));
        send_item(make_particle(20000000, -20000000, -3, 3, 0, 0, 32'h0100_0000));
        send_item(make_particle(20000000, -20000000, 5, -5, 0, 0, 32'h0100_0000));
        send_item(make_particle(100, -100, 0, 0, 5, -5, 32'h7FFF_FFFF));
        send_item(make_particle(0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h0100_0000));
        send_item(make_particle(0, 0, 0, 0, -3, 3, 32'h0200_0000));
        send_item(make_particle(0, 0, 0, 0, 32'h7FFF_FFFF, -7, 32'h7FFF_FFFF));
        send_item(make_particle(16609443, -16609443, 1, -1, 0, 0, 32'h0100_0000));
        send_item(make_particle(-1, -1, -1, -1, -1, -1, 32'h7FFF_FFFF));
        send_item(make_particle(16000000, -16000000, 600000, -600000,
                                2000000, -2000000, 32'h0080_0000));
        drain();
    endtask

    // Register extremes, including a zero border that can hit both walls
    task automatic test_register_extremes();
        set_regs(REG_MAX, REG_MAX, '0);
        send_item(make_particle(0, 0, 0, 0, 0, 0, 0));
        send_item(make_particle(5, -5, 7, -7, 0, 0, 32'h0100_0000));
        send_item(make_particle(0, 0, -9, 9, 32'h7FFF_FFFF, 32'h8000_0000, 1));
        send_random(25);
        drain();
        set_regs('0, '0, REG_MAX);
        send_item(make_particle(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        send_random(20);
        drain();
        set_regs(REG_ONE, REG_ONE, REG_ONE);
        send_random(20);
        drain();
    endtask

    // A write to the unused index must change nothing
    task automatic test_unused_index();
        set_regs(25'd5033165, 25'd671089, 25'd16609444);
        write_reg(CFG_UNUSED, 25'($urandom));
        write_reg(CFG_UNUSED, REG_MAX);
        send_random(20);
        drain();
    endtask

    // Long receiver hold while items keep coming: the pipeline must fill and stall
    task automatic test_backpressure();
        src_idle_pct = 0;
        hold_req     = 1'b1;
        send_random(80);
        src_idle_pct = IDLE_PCT;
        drain();
    endtask

    // Random traffic over several register settings, first stretch with no idling
    task automatic test_random();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random(150);
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
        send_random(100);
        drain();
        repeat (4) begin
            set_regs(25'($urandom_range(REG_MAX)), 25'($urandom_range(4000000)),
                     25'($urandom_range(REG_MAX)));
            send_random(90);
            drain();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_TIME_STEP;
        i_cfg_data    = '0;
        fail_count    = 0;
        quiet_cycles  = 0;
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;
        hold_req      = 1'b0;
        step_reg      = TIME_STEP_RST;
        limit_reg     = ACCEL_LIMIT_RST;
        border_reg    = BORDER_RST;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_register_extremes();
        test_unused_index();
        test_backpressure();
        test_random();

        repeat (PIPE_DEPTH) @(posedge i_clk);
        if (fail_count == 0 && pending_updates.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
